// ===== sv/ssc_pkg.sv =====
// ----------------------------------------------------------------------------
// ssc_pkg
// Shared types, codes and field layout of the stimulation session controller.
// ----------------------------------------------------------------------------
package ssc_pkg;

	localparam int FREQ_W   = 20;
	localparam int LEVEL_W  = 8;
	localparam int DUR_W    = 16;
	localparam int KIND_W   = 3;
	localparam int RC_W     = 3;
	localparam int MODE_W   = 2;
	localparam int STOP_W   = 3;
	localparam int SESS_W   = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 20;

	localparam int S_DATA_W = 56;
	localparam int M_DATA_W = 32;

	localparam int FREQ_LSB   = 0;
	localparam int BRIGHT_LSB = FREQ_LSB + FREQ_W;
	localparam int VOL_LSB    = BRIGHT_LSB + LEVEL_W;
	localparam int DUR_LSB    = VOL_LSB + LEVEL_W;
	localparam int CAUSE_LSB  = DUR_LSB + DUR_W;

	// product of duration and frequency, and a running multiple of the divisor
	localparam int PROD_W = FREQ_W + DUR_W;
	localparam int ACC_W  = PROD_W + 1;
	localparam int HALF_PERIOD_DIVISOR = 500;

	localparam int QUEUE_DEPTH = 2;

	localparam logic [FREQ_W-1:0]  MIN_FREQ_RESET = FREQ_W'(36000);
	localparam logic [FREQ_W-1:0]  MAX_FREQ_RESET = FREQ_W'(44000);
	localparam logic [LEVEL_W-1:0] MAX_BRIGHT_RESET = LEVEL_W'(40);
	localparam logic [LEVEL_W-1:0] MAX_VOL_RESET = LEVEL_W'(40);
	localparam logic [DUR_W-1:0]   MAX_DUR_RESET = DUR_W'(900);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_FREQ   = 3'd0,
		REG_MAX_FREQ   = 3'd1,
		REG_MAX_BRIGHT = 3'd2,
		REG_MAX_VOL    = 3'd3,
		REG_MAX_DUR    = 3'd4
	} reg_idx_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_START  = 3'd0,
		KIND_STOP   = 3'd1,
		KIND_ESTOP  = 3'd2,
		KIND_UNLOCK = 3'd3,
		KIND_TICK   = 3'd4
	} kind_t;

	typedef enum logic [RC_W-1:0] {
		RC_OK       = 3'd0,
		RC_FREQ     = 3'd1,
		RC_BRIGHT   = 3'd2,
		RC_VOLUME   = 3'd3,
		RC_ZERO_DUR = 3'd4,
		RC_DUR_CAP  = 3'd5,
		RC_BUSY     = 3'd6,
		RC_LOCKED   = 3'd7
	} rc_t;

	typedef enum logic [STOP_W-1:0] {
		STOP_NONE      = 3'd0,
		STOP_COMPLETED = 3'd1,
		STOP_HOST      = 3'd2,
		STOP_BUTTON    = 3'd3,
		STOP_FAULT     = 3'd4
	} stop_t;

	typedef struct packed {
		kind_t             kind;
		rc_t               check;
		logic              cause;
		logic [PROD_W-1:0] product;
	} item_t;

endpackage

// ===== sv/ssc_front.sv =====
// ----------------------------------------------------------------------------
// ssc_front
// Holds the envelope registers, takes requests and classifies start requests.
// ----------------------------------------------------------------------------
module ssc_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// frequency_mhz, brightness, volume, duration_seconds, estop_cause
	input  logic [ssc_pkg::S_DATA_W-1:0]   s_tdata,
	// kind
	input  logic [ssc_pkg::KIND_W-1:0]     s_tuser,
	input  logic                           cfg_valid,
	input  logic [ssc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ssc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           queue_full,
	output logic                           push,
	output ssc_pkg::item_t                 item
);
	import ssc_pkg::*;

	logic [FREQ_W-1:0]  min_freq_q;
	logic [FREQ_W-1:0]  max_freq_q;
	logic [LEVEL_W-1:0] max_bright_q;
	logic [LEVEL_W-1:0] max_vol_q;
	logic [DUR_W-1:0]   max_dur_q;

	logic [FREQ_W-1:0]  freq;
	logic [LEVEL_W-1:0] bright;
	logic [LEVEL_W-1:0] vol;
	logic [DUR_W-1:0]   dur;
	rc_t                check;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_freq_q   <= MIN_FREQ_RESET;
			max_freq_q   <= MAX_FREQ_RESET;
			max_bright_q <= MAX_BRIGHT_RESET;
			max_vol_q    <= MAX_VOL_RESET;
			max_dur_q    <= MAX_DUR_RESET;
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_MIN_FREQ:   min_freq_q   <= cfg_data;
				REG_MAX_FREQ:   max_freq_q   <= cfg_data;
				REG_MAX_BRIGHT: max_bright_q <= cfg_data[LEVEL_W-1:0];
				REG_MAX_VOL:    max_vol_q    <= cfg_data[LEVEL_W-1:0];
				REG_MAX_DUR:    max_dur_q    <= cfg_data[DUR_W-1:0];
				default: ;
			endcase
		end
	end

	assign freq   = s_tdata[BRIGHT_LSB-1:FREQ_LSB];
	assign bright = s_tdata[VOL_LSB-1:BRIGHT_LSB];
	assign vol    = s_tdata[DUR_LSB-1:VOL_LSB];
	assign dur    = s_tdata[CAUSE_LSB-1:DUR_LSB];

	always_comb begin
		priority if (freq < min_freq_q || freq > max_freq_q) begin
			check = RC_FREQ;
		end else if (bright > max_bright_q) begin
			check = RC_BRIGHT;
		end else if (vol > max_vol_q) begin
			check = RC_VOLUME;
		end else if (dur == '0) begin
			check = RC_ZERO_DUR;
		end else if (dur > max_dur_q) begin
			check = RC_DUR_CAP;
		end else begin
			check = RC_OK;
		end
	end

	assign s_tready     = !queue_full;
	assign push         = s_tvalid && !queue_full;
	assign item.kind    = kind_t'(s_tuser);
	assign item.check   = check;
	assign item.cause   = s_tdata[CAUSE_LSB];
	assign item.product = PROD_W'(dur) * PROD_W'(freq);

endmodule

// ===== sv/ssc_queue.sv =====
// ----------------------------------------------------------------------------
// ssc_queue
// Short request queue between the classifier and the session engine.
// ----------------------------------------------------------------------------
module ssc_queue #(
	parameter int DEPTH = ssc_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ssc_pkg::item_t push_item,
	input  logic           pop,
	output logic           full,
	output logic           not_empty,
	output ssc_pkg::item_t head
);
	import ssc_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	item_t              slot_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign full      = count_q == CNT_W'(DEPTH);
	assign not_empty = count_q != '0;
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign head      = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ===== sv/ssc_back.sv =====
// ----------------------------------------------------------------------------
// ssc_back
// Session engine: mode, envelope, half-period count and the result register.
// ----------------------------------------------------------------------------
module ssc_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	input  ssc_pkg::item_t               item,
	output logic                         pop,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// return_code, mode_now, envelope_level, tick_continues, stop_reason,
	// session_number
	output logic [ssc_pkg::M_DATA_W-1:0] m_tdata
);
	import ssc_pkg::*;

	typedef enum logic [MODE_W-1:0] {
		MODE_IDLE    = 2'd0,
		MODE_RUNNING = 2'd1,
		MODE_LOCKED  = 2'd2
	} mode_t;

	localparam logic [ACC_W-1:0] DIV_STEP = ACC_W'(HALF_PERIOD_DIVISOR);

	mode_t              mode_q;
	logic               env_q;
	logic [SESS_W-1:0]  sess_q;
	stop_t              stop_q;
	logic [ACC_W-1:0]   acc_q;
	logic [PROD_W-1:0]  prod_q;
	logic               out_valid_q;
	logic [M_DATA_W-1:0] out_data_q;

	mode_t              mode_d;
	logic               env_d;
	logic [SESS_W-1:0]  sess_d;
	stop_t              stop_d;
	rc_t                rc_d;
	logic               cont_d;
	logic               start_ok;
	logic               tick_run;
	logic [ACC_W-1:0]   acc_next;
	logic               done;

	assign pop      = item_valid && (!out_valid_q || m_tready);
	assign acc_next = acc_q + DIV_STEP;
	// elapsed reaches the total once 500 * (elapsed + 1) exceeds the product
	assign done     = acc_next > {1'b0, prod_q};

	always_comb begin
		mode_d   = mode_q;
		env_d    = env_q;
		sess_d   = sess_q;
		stop_d   = stop_q;
		rc_d     = RC_OK;
		cont_d   = 1'b0;
		start_ok = 1'b0;
		tick_run = 1'b0;
		unique case (item.kind)
			KIND_START: begin
				unique case (mode_q)
					MODE_LOCKED:  rc_d = RC_LOCKED;
					MODE_RUNNING: rc_d = RC_BUSY;
					default: begin
						rc_d = item.check;
						if (item.check == RC_OK) begin
							start_ok = 1'b1;
							env_d    = 1'b0;
							sess_d   = sess_q + 1'b1;
							stop_d   = STOP_NONE;
							mode_d   = MODE_RUNNING;
						end
					end
				endcase
			end
			KIND_STOP: begin
				if (mode_q == MODE_RUNNING) begin
					mode_d = MODE_IDLE;
					env_d  = 1'b0;
					stop_d = STOP_HOST;
				end
			end
			KIND_ESTOP: begin
				mode_d = MODE_LOCKED;
				env_d  = 1'b0;
				stop_d = item.cause ? STOP_FAULT : STOP_BUTTON;
			end
			KIND_UNLOCK: begin
				if (mode_q == MODE_LOCKED) begin
					mode_d = MODE_IDLE;
				end
			end
			KIND_TICK: begin
				if (mode_q != MODE_RUNNING) begin
					env_d = 1'b0;
				end else begin
					tick_run = 1'b1;
					if (done) begin
						mode_d = MODE_IDLE;
						env_d  = 1'b0;
						stop_d = STOP_COMPLETED;
					end else begin
						env_d  = !env_q;
						cont_d = 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_IDLE;
			env_q       <= 1'b0;
			sess_q      <= '0;
			stop_q      <= STOP_NONE;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				mode_q      <= mode_d;
				env_q       <= env_d;
				sess_q      <= sess_d;
				stop_q      <= stop_d;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_data_q <= {(M_DATA_W - RC_W - MODE_W - 2 - STOP_W - SESS_W)'(0),
				sess_d, stop_d, cont_d, env_d, mode_d, rc_d};
			if (start_ok) begin
				acc_q  <= DIV_STEP;
				prod_q <= item.product;
			end else if (tick_run) begin
				acc_q <= acc_next;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

// ===== sv/stimulation_session_controller_unit.sv =====
// ----------------------------------------------------------------------------
// stimulation_session_controller_unit
// Safety session controller for a periodic stimulus with envelope checks.
// ----------------------------------------------------------------------------
// a result is registered on m_tdata after its request has passed through the queue
// the session engine takes one request per cycle while the output is not stalled
// the queue (QUEUE_DEPTH entries) fills during output stalls, input resumes
// in the cycle after the output does
// reset: mode idle, envelope low, counters cleared, envelope limits at defaults
module stimulation_session_controller_unit #(
	parameter int QUEUE_DEPTH = ssc_pkg::QUEUE_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// frequency_mhz, brightness, volume, duration_seconds, estop_cause
	input  logic [ssc_pkg::S_DATA_W-1:0]   s_tdata,
	// kind
	input  logic [ssc_pkg::KIND_W-1:0]     s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// return_code, mode_now, envelope_level, tick_continues, stop_reason,
	// session_number
	output logic [ssc_pkg::M_DATA_W-1:0]   m_tdata,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [ssc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ssc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import ssc_pkg::*;

	logic  push;
	logic  pop;
	logic  queue_full;
	logic  queue_valid;
	item_t front_item;
	item_t head_item;

	assign cfg_ready = 1'b1;

	ssc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.queue_full (queue_full),
		.push       (push),
		.item       (front_item)
	);

	ssc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (front_item),
		.pop       (pop),
		.full      (queue_full),
		.not_empty (queue_valid),
		.head      (head_item)
	);

	ssc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (queue_valid),
		.item       (head_item),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

endmodule

// ===== sv/ssc_checker.sv =====
// ----------------------------------------------------------------------------
// ssc_checker
// Port-level checks on the result stream of the session controller.
// ----------------------------------------------------------------------------
module ssc_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [ssc_pkg::M_DATA_W-1:0] m_tdata
);
	import ssc_pkg::*;

	localparam logic [MODE_W-1:0] MODE_RUN  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_LOCK = 2'd2;

	logic [RC_W-1:0]   rc;
	logic [MODE_W-1:0] mode;
	logic              env;
	logic              cont;

	assign rc   = m_tdata[2:0];
	assign mode = m_tdata[4:3];
	assign env  = m_tdata[5];
	assign cont = m_tdata[6];

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// envelope only high while a session runs
	a_env: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && env |-> mode == MODE_RUN)
		else $error("envelope high outside a session");

	// a continuing tick means a running session and no error code
	a_cont: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && cont |-> mode == MODE_RUN && rc == RC_OK)
		else $error("tick continues outside a session");

	// busy and locked codes agree with the reported mode
	a_rc_mode: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (rc != RC_BUSY || mode == MODE_RUN) && (rc != RC_LOCKED || mode == MODE_LOCK))
		else $error("return code disagrees with mode");

endmodule

bind stimulation_session_controller_unit ssc_checker u_ssc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
